[hw/rtl/nlp_pkg.sv]
// Package for the next lexicographic permutation block.
// Holds the fixed payload width used by the permutation block; depends on nothing.
`default_nettype none

package nlp_pkg;

    // Width of the packed sequence on both channels
    localparam int DATA_W = 40;

endpackage : nlp_pkg

`default_nettype wire

[hw/rtl/next_lexicographic_permutation.sv]
// Throughput: one item per cycle unless m_ready stalls the output; four register
// stages (ascent compare, pivot select, successor search, swap and suffix reversal)
// each take one item a cycle, and the result leaves on the m_ side.
// Stalls back-propagate through per-stage valid bits; no item is lost or repeated.
// Reset: synchronous, active-low aresetn clears every stage valid bit.
`default_nettype none

module next_lexicographic_permutation #(
    parameter int ELEMENT_COUNT = 10,
    parameter int ELEMENT_BITS  = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [nlp_pkg::DATA_W-1:0]  s_perm_in,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [nlp_pkg::DATA_W-1:0]  m_perm_out,
    output logic                             m_wrapped
);

    import nlp_pkg::*;

    localparam int N      = ELEMENT_COUNT;
    localparam int B      = ELEMENT_BITS;
    localparam int PACK_W = N * B;
    localparam int IW     = $clog2(N);

    // ------------------------------------------------------------------
    // Stage enables: a stage advances when it is empty or the one after
    // it advances. The output register is the last stage.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4     = ~v4_reg | m_ready;
    assign en3     = ~v3_reg | en4;
    assign en2     = ~v2_reg | en3;
    assign en1     = ~v1_reg | en2;
    assign s_ready = en1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack and flag every ascent e[i] < e[i+1].
    // Elements that would sit above the field read as zero, so pad the
    // input word before slicing.
    // ------------------------------------------------------------------
    logic [PACK_W+DATA_W-1:0] in_ext;
    logic [PACK_W-1:0]        e1_next, e1_reg;
    logic [N-2:0]             asc1_next, asc1_reg;

    assign in_ext  = {{PACK_W{1'b0}}, s_perm_in};
    assign e1_next = in_ext[PACK_W-1:0];

    always_comb begin
        for (int i = 0; i < N - 1; i++) begin
            asc1_next[i] = in_ext[i*B +: B] < in_ext[(i+1)*B +: B];
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            e1_reg   <= e1_next;
            asc1_reg <= asc1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the rightmost ascent as pivot and fetch its value.
    // ------------------------------------------------------------------
    logic [N-2:0]    piv_oh;
    logic [IW-1:0]   p2_next, p2_reg;
    logic            found2_next, found2_reg;
    logic [B-1:0]    pv2_next, pv2_reg;
    logic [PACK_W-1:0] e2_reg;

    nlp_prio #(
        .WIDTH (N - 1),
        .IDX_W (IW)
    ) u_pivot (
        .req    (asc1_reg),
        .onehot (piv_oh),
        .idx    (p2_next),
        .found  (found2_next)
    );

    always_comb begin
        pv2_next = '0;
        for (int i = 0; i < N - 1; i++) begin
            if (piv_oh[i]) begin
                pv2_next = pv2_next | e1_reg[i*B +: B];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            e2_reg     <= e1_reg;
            p2_reg     <= p2_next;
            found2_reg <= found2_next;
            pv2_reg    <= pv2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: find the rightmost element beyond the pivot that is
    // strictly greater than it; one always exists when a pivot exists.
    // ------------------------------------------------------------------
    logic [N-1:0]      gt3;
    logic [N-1:0]      kh3_next, kh3_reg;
    logic [IW-1:0]     k3_idx;
    logic [IW-1:0]     k3_reg;
    logic              k3_any;
    logic [PACK_W-1:0] e3_reg;
    logic [IW-1:0]     p3_reg;
    logic              found3_reg;
    logic [B-1:0]      pv3_reg;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            gt3[k] = (IW'(k) > p2_reg) && (pv2_reg < e2_reg[k*B +: B]);
        end
    end

    nlp_prio #(
        .WIDTH (N),
        .IDX_W (IW)
    ) u_succ (
        .req    (gt3),
        .onehot (kh3_next),
        .idx    (k3_idx),
        .found  (k3_any)
    );

    always_ff @(posedge aclk) begin
        if (en3) begin
            e3_reg     <= e2_reg;
            p3_reg     <= p2_reg;
            // A pivot always has a larger element to its right
            found3_reg <= found2_reg & k3_any;
            pv3_reg    <= pv2_reg;
            kh3_reg    <= kh3_next;
            k3_reg     <= k3_idx;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: swap pivot and successor, reverse the suffix after the
    // pivot. Without a pivot, reverse the whole sequence and flag wrap.
    // ------------------------------------------------------------------
    logic [B-1:0]             ek4;
    logic [IW-1:0]            src4;
    logic [B-1:0]             val4;
    logic [PACK_W-1:0]        perm4;
    logic [PACK_W+DATA_W-1:0] out_ext;
    logic [DATA_W-1:0]        m_perm_out_next, m_perm_out_reg;
    logic                     m_wrapped_next, m_wrapped_reg;

    always_comb begin
        ek4   = '0;
        src4  = '0;
        val4  = '0;
        perm4 = '0;
        for (int s = 0; s < N; s++) begin
            if (kh3_reg[s]) begin
                ek4 = ek4 | e3_reg[s*B +: B];
            end
        end
        for (int j = 0; j < N; j++) begin
            // Mirror position of j inside the suffix p+1 .. N-1
            src4 = p3_reg + IW'(N - j);
            val4 = '0;
            if (!found3_reg) begin
                val4 = e3_reg[(N-1-j)*B +: B];
            end else if (IW'(j) < p3_reg) begin
                val4 = e3_reg[j*B +: B];
            end else if (IW'(j) == p3_reg) begin
                val4 = ek4;
            end else begin
                for (int s = 0; s < N; s++) begin
                    if (IW'(s) == src4) begin
                        val4 = (src4 == k3_reg) ? pv3_reg : e3_reg[s*B +: B];
                    end
                end
            end
            perm4[j*B +: B] = val4;
        end
    end

    // Drop anything packed above the field, zero-fill the top when the sequence is narrower
    assign out_ext         = {{DATA_W{1'b0}}, perm4};
    assign m_perm_out_next = out_ext[DATA_W-1:0];
    assign m_wrapped_next  = ~found3_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            m_perm_out_reg <= m_perm_out_next;
            m_wrapped_reg  <= m_wrapped_next;
        end
    end

    assign m_perm_out = m_perm_out_reg;
    assign m_wrapped  = m_wrapped_reg;

`ifndef SYNTH
    // A found pivot in flight always selects exactly one successor
    assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && found3_reg |-> $onehot(kh3_reg))
        else $error("successor select is not one-hot");

    // The input side only stalls when every stage is full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg && v4_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    // A stage holding an item that cannot advance keeps it
    assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !en3 |=> v3_reg && $stable(e3_reg))
        else $error("stalled stage lost its item");
`endif

endmodule : next_lexicographic_permutation

`default_nettype wire

[hw/rtl/nlp_prio.sv]
// Highest-set-bit priority encoder for the permutation pipeline.
// Gives a one-hot grant, its binary index and an any-set flag; no package use.
`default_nettype none

module nlp_prio #(
    parameter int WIDTH = 9,
    parameter int IDX_W = 4
) (
    input  wire logic [WIDTH-1:0] req,
    output logic      [WIDTH-1:0] onehot,
    output logic      [IDX_W-1:0] idx,
    output logic                  found
);

    // Each bit wins when no higher bit is set
    always_comb begin
        onehot = '0;
        idx    = '0;
        for (int i = 0; i < WIDTH; i++) begin
            onehot[i] = req[i] & ~(|(req >> (i + 1)));
        end
        for (int i = 0; i < WIDTH; i++) begin
            if (onehot[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        found = |req;
    end

endmodule : nlp_prio

`default_nettype wire
